// ===== src/utfc_pkg.sv =====
// Shared constants and types for the UTF-8 transcoder.
package utfc_pkg;

   localparam logic [2:0] FORM_ASCII   = 3'd0;
   localparam logic [2:0] FORM_UTF8    = 3'd1;
   localparam logic [2:0] FORM_UTF16LE = 3'd2;
   localparam logic [2:0] FORM_UTF16BE = 3'd3;
   localparam logic [2:0] FORM_UTF32LE = 3'd4;
   localparam logic [2:0] FORM_UTF32BE = 3'd5;
   localparam logic [2:0] FORM_CESU8   = 3'd6;
   localparam logic [2:0] FORM_UNUSED  = 3'd7;
   localparam logic [2:0] FORM_RESET   = FORM_UTF8;

   localparam int MAX_BYTES = 6;
   localparam int CNT_W     = 3;
   localparam int CODE_W    = 21;

   // Bytes produced by one input beat, emitted from data[0] upward.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] data;
      logic [CNT_W-1:0]          cnt;
      logic                      last;
      logic                      err;
   } pack_type;

endpackage

// ===== src/utf8_to_unicode_form_transcoder_core.sv =====
// Top level of the UTF-8 to UTF-16/UTF-32/CESU-8 transcoder.
//
//   channel  direction  handshake           payload
//   req      in         req_valid/req_stall req_in_byte
//   rsp      out        rsp_valid/rsp_stall rsp_out_byte, rsp_char_last, rsp_error
//   csr      in         csr_wr_en           csr_wr_data (target form)
//
// An input beat is decoded and encoded in the cycle it is accepted and lands in
// a result buffer of up to six bytes; the buffer drains one byte per cycle while
// rsp is not stalled. A new byte is taken in the same cycle as the buffer's last
// byte leaves, or whenever the buffer is empty.
// Synchronous reset empties the buffer, clears the gathered character and
// selects UTF-8 passthrough. A stall on rsp holds the current byte and stalls req.
module utf8_to_unicode_form_transcoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_char_last,
   output logic       rsp_error,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);

   logic [2:0]                  form_ff, form_in;
   logic [1:0]                  rem_ff, rem_in;
   logic [utfc_pkg::CODE_W-1:0] accum_ff, accum_in;
   utfc_pkg::pack_type          pack_ff, pack_in;
   logic [utfc_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic [utfc_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   logic [1:0]                  enc_rem;
   logic [utfc_pkg::CODE_W-1:0] enc_accum;
   utfc_pkg::pack_type          enc_pack;

   logic busy;
   logic last_beat;
   logic finish;
   logic take;

   utfc_encode u_encode (
      .form       (form_ff),
      .in_byte    (req_in_byte),
      .rem        (rem_ff),
      .accum      (accum_ff),
      .rem_next   (enc_rem),
      .accum_next (enc_accum),
      .pack       (enc_pack)
   );

   always_comb begin
      busy      = (cnt_ff != '0);
      last_beat = (idx_ff == 3'(cnt_ff - 3'd1));
      finish    = busy && !rsp_stall && last_beat;
      req_stall = busy && !finish;
      take      = req_valid && !req_stall;

      rsp_valid     = busy;
      rsp_out_byte  = pack_ff.data[idx_ff];
      rsp_char_last = last_beat && pack_ff.last;
      rsp_error     = pack_ff.err;

      form_in = form_ff;
      if (csr_wr_en && csr_wr_data != utfc_pkg::FORM_UNUSED) begin
         form_in = csr_wr_data;
      end

      rem_in   = rem_ff;
      accum_in = accum_ff;
      pack_in  = pack_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      if (take) begin
         rem_in   = enc_rem;
         accum_in = enc_accum;
         pack_in  = enc_pack;
         idx_in   = '0;
         cnt_in   = enc_pack.cnt;
      end else if (finish) begin
         cnt_in = '0;
         idx_in = '0;
      end else if (busy && !rsp_stall) begin
         idx_in = 3'(idx_ff + 3'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         form_ff  <= utfc_pkg::FORM_RESET;
         rem_ff   <= '0;
         accum_ff <= '0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         form_ff  <= form_in;
         rem_ff   <= rem_in;
         accum_ff <= accum_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
      pack_ff <= pack_in;
   end

endmodule

// ===== src/utfc_encode.sv =====
// Decode step and output-form encoder for one input byte.
module utfc_encode (
   input  logic [2:0]                  form,
   input  logic [7:0]                  in_byte,
   input  logic [1:0]                  rem,
   input  logic [utfc_pkg::CODE_W-1:0] accum,
   output logic [1:0]                  rem_next,
   output logic [utfc_pkg::CODE_W-1:0] accum_next,
   output utfc_pkg::pack_type          pack
);

   logic [utfc_pkg::CODE_W-1:0] code;
   logic [utfc_pkg::CODE_W-1:0] ofs;
   logic [15:0]                 su;
   logic [15:0]                 sl;
   logic                        big;
   logic                        done;

   always_comb begin
      // gather the code point
      if (rem == 2'd0) begin
         if (!in_byte[7]) begin
            code     = {13'd0, in_byte};
            rem_next = 2'd0;
         end else if (in_byte[7:5] == 3'b110) begin
            code     = {16'd0, in_byte[4:0]};
            rem_next = 2'd1;
         end else if (in_byte[7:4] == 4'b1110) begin
            code     = {17'd0, in_byte[3:0]};
            rem_next = 2'd2;
         end else begin
            code     = {18'd0, in_byte[2:0]};
            rem_next = 2'd3;
         end
      end else begin
         code     = {accum[14:0], in_byte[5:0]};
         rem_next = 2'(rem - 2'd1);
      end
      accum_next = code;
      done       = (rem_next == 2'd0);

      big = (code[20:16] != 5'd0);
      ofs = code - 21'h10000;
      su  = 16'hD800 | {5'd0, ofs[20:10]};
      sl  = 16'hDC00 | {6'd0, ofs[9:0]};

      pack.data = '0;
      pack.cnt  = '0;
      pack.last = 1'b1;
      pack.err  = 1'b0;

      case (form)
         utfc_pkg::FORM_ASCII: begin
            // every byte stands alone; drop any open character
            rem_next     = 2'd0;
            accum_next   = accum;
            pack.cnt     = 3'd1;
            pack.err     = in_byte[7];
            pack.data[0] = in_byte[7] ? 8'd0 : in_byte;
         end
         utfc_pkg::FORM_UTF8: begin
            pack.cnt     = 3'd1;
            pack.last    = done;
            pack.data[0] = in_byte;
         end
         utfc_pkg::FORM_UTF16LE, utfc_pkg::FORM_UTF16BE: begin
            if (big) begin
               pack.cnt  = 3'd4;
               pack.data[0] = su[7:0];
               pack.data[1] = su[15:8];
               pack.data[2] = sl[7:0];
               pack.data[3] = sl[15:8];
            end else begin
               pack.cnt  = 3'd2;
               pack.data[0] = code[7:0];
               pack.data[1] = code[15:8];
            end
            if (form == utfc_pkg::FORM_UTF16BE) begin
               // swap bytes within each 16-bit unit
               pack.data[0] = big ? su[15:8] : code[15:8];
               pack.data[1] = big ? su[7:0]  : code[7:0];
               if (big) begin
                  pack.data[2] = sl[15:8];
                  pack.data[3] = sl[7:0];
               end
            end
         end
         utfc_pkg::FORM_UTF32LE: begin
            pack.cnt     = 3'd4;
            pack.data[0] = code[7:0];
            pack.data[1] = code[15:8];
            pack.data[2] = {3'd0, code[20:16]};
            pack.data[3] = 8'd0;
         end
         utfc_pkg::FORM_UTF32BE: begin
            pack.cnt     = 3'd4;
            pack.data[0] = 8'd0;
            pack.data[1] = {3'd0, code[20:16]};
            pack.data[2] = code[15:8];
            pack.data[3] = code[7:0];
         end
         default: begin
            if (code < 21'h80) begin
               pack.cnt     = 3'd1;
               pack.data[0] = code[7:0];
            end else if (code < 21'h800) begin
               pack.cnt     = 3'd2;
               pack.data[0] = {3'b110, code[10:6]};
               pack.data[1] = {2'b10, code[5:0]};
            end else if (!big) begin
               pack.cnt     = 3'd3;
               pack.data[0] = {4'b1110, code[15:12]};
               pack.data[1] = {2'b10, code[11:6]};
               pack.data[2] = {2'b10, code[5:0]};
            end else begin
               // surrogate pair, each half as a 3-byte sequence
               pack.cnt     = 3'd6;
               pack.data[0] = {4'b1110, su[15:12]};
               pack.data[1] = {2'b10, su[11:6]};
               pack.data[2] = {2'b10, su[5:0]};
               pack.data[3] = {4'b1110, sl[15:12]};
               pack.data[4] = {2'b10, sl[11:6]};
               pack.data[5] = {2'b10, sl[5:0]};
            end
         end
      endcase

      // hold output until the character's final byte
      if (form != utfc_pkg::FORM_ASCII && form != utfc_pkg::FORM_UTF8 && !done) begin
         pack.cnt = '0;
      end
   end

endmodule

// ===== src/utfc_checker.sv =====
// Port-level assertions for the transcoder core, bound to the top level.
module utfc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic [7:0] req_in_byte,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_char_last,
   input logic       rsp_error,
   input logic       csr_wr_en,
   input logic [2:0] csr_wr_data
);

   // a stalled result beat stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // an error beat is a zero byte that closes its character
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_out_byte == 8'd0 && rsp_char_last)
      else $error("error beat with nonzero byte or open character");

   // the result buffer is empty after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

   // input only stalls while results are pending
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("req stalled with empty result buffer");

endmodule

bind utf8_to_unicode_form_transcoder_core utfc_checker u_utfc_checker (.*);

// ===== verif/utf8_transcoder_checker.sv =====
// Checker for the UTF-8 transcoder: predicts output beats and compares them.
module utf8_transcoder_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_char_last,
   input  logic       rsp_error,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data,
   output int         fail_count,
   output int         expected_left,
   output int         bytes_in,
   output int         bytes_out
);

   localparam int PRINT_CAP = 30;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } out_beat_type;

   out_beat_type                expected_out_q[$];
   out_beat_type                want;
   logic [2:0]                  form;
   logic [1:0]                  cont_left;
   logic [utfc_pkg::CODE_W-1:0] code_acc;

   task automatic report_mismatch(input string what);
      if (fail_count < PRINT_CAP)
         $display("mismatch at %0t: %s", $time, what);
      fail_count++;
   endtask

   task automatic push_beat(input logic [7:0] d, input logic l, input logic e);
      expected_out_q.push_back(out_beat_type'{data: d, last: l, err: e});
   endtask

   // Byte order within a 16-bit unit follows the selected endianness.
   task automatic push_unit16(input logic [15:0] u);
      if (form == utfc_pkg::FORM_UTF16BE) begin
         push_beat(u[15:8], 1'b0, 1'b0);
         push_beat(u[7:0], 1'b0, 1'b0);
      end else begin
         push_beat(u[7:0], 1'b0, 1'b0);
         push_beat(u[15:8], 1'b0, 1'b0);
      end
   endtask

   task automatic push_cesu3(input logic [15:0] v);
      push_beat(8'hE0 | {4'd0, v[15:12]}, 1'b0, 1'b0);
      push_beat(8'h80 | {2'd0, v[11:6]}, 1'b0, 1'b0);
      push_beat(8'h80 | {2'd0, v[5:0]}, 1'b0, 1'b0);
   endtask

   task automatic encode_code_point(input logic [utfc_pkg::CODE_W-1:0] code);
      logic                        big;
      logic [utfc_pkg::CODE_W-1:0] offset;
      logic [15:0]                 hi_unit;
      logic [15:0]                 lo_unit;
      out_beat_type                tail;
      big     = code >= 21'h10000;
      offset  = code - 21'h10000;
      // keep surrogates to 16 bits even when the code point is out of range
      hi_unit = 16'hD800 | 16'(offset >> 10);
      lo_unit = 16'hDC00 | {6'd0, offset[9:0]};
      case (form)
         utfc_pkg::FORM_UTF16LE, utfc_pkg::FORM_UTF16BE: begin
            if (big) begin
               push_unit16(hi_unit);
               push_unit16(lo_unit);
            end else begin
               push_unit16(code[15:0]);
            end
         end
         utfc_pkg::FORM_UTF32LE: begin
            push_beat(code[7:0], 1'b0, 1'b0);
            push_beat(code[15:8], 1'b0, 1'b0);
            push_beat({3'd0, code[20:16]}, 1'b0, 1'b0);
            push_beat(8'h00, 1'b0, 1'b0);
         end
         utfc_pkg::FORM_UTF32BE: begin
            push_beat(8'h00, 1'b0, 1'b0);
            push_beat({3'd0, code[20:16]}, 1'b0, 1'b0);
            push_beat(code[15:8], 1'b0, 1'b0);
            push_beat(code[7:0], 1'b0, 1'b0);
         end
         default: begin
            if (code < 21'h80) begin
               push_beat(code[7:0], 1'b0, 1'b0);
            end else if (code < 21'h800) begin
               push_beat(8'hC0 | {3'd0, code[10:6]}, 1'b0, 1'b0);
               push_beat(8'h80 | {2'd0, code[5:0]}, 1'b0, 1'b0);
            end else if (!big) begin
               push_cesu3(code[15:0]);
            end else begin
               push_cesu3(hi_unit);
               push_cesu3(lo_unit);
            end
         end
      endcase
      tail = expected_out_q.pop_back();
      tail.last = 1'b1;
      expected_out_q.push_back(tail);
   endtask

   task automatic predict_beat(input logic [7:0] b);
      logic done;
      if (form == utfc_pkg::FORM_ASCII) begin
         // every byte stands alone here; drop any open character
         cont_left = 2'd0;
         if (b < 8'h80)
            push_beat(b, 1'b1, 1'b0);
         else
            push_beat(8'h00, 1'b1, 1'b1);
         return;
      end
      if (cont_left == 2'd0) begin
         if (b[7] == 1'b0) begin
            code_acc  = {14'd0, b[6:0]};
            cont_left = 2'd0;
         end else if (b[7:5] == 3'b110) begin
            code_acc  = {16'd0, b[4:0]};
            cont_left = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            code_acc  = {17'd0, b[3:0]};
            cont_left = 2'd2;
         end else begin
            code_acc  = {18'd0, b[2:0]};
            cont_left = 2'd3;
         end
      end else begin
         code_acc  = {code_acc[14:0], b[5:0]};
         cont_left = cont_left - 2'd1;
      end
      done = cont_left == 2'd0;
      if (form == utfc_pkg::FORM_UTF8)
         push_beat(b, done, 1'b0);
      else if (done)
         encode_code_point(code_acc);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         form          = utfc_pkg::FORM_RESET;
         cont_left     = 2'd0;
         code_acc      = '0;
         fail_count    = 0;
         bytes_in      = 0;
         bytes_out     = 0;
         expected_left = 0;
         expected_out_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            bytes_out++;
            if (expected_out_q.size() == 0) begin
               report_mismatch($sformatf("unexpected beat %02h last %0d err %0d",
                                         rsp_out_byte, rsp_char_last, rsp_error));
            end else begin
               want = expected_out_q.pop_front();
               if (rsp_out_byte !== want.data || rsp_char_last !== want.last ||
                   rsp_error !== want.err)
                  report_mismatch($sformatf(
                     "got %02h last %0d err %0d, expected %02h last %0d err %0d",
                     rsp_out_byte, rsp_char_last, rsp_error,
                     want.data, want.last, want.err));
            end
         end
         if (req_valid && !req_stall) begin
            bytes_in++;
            predict_beat(req_in_byte);
         end
         if (csr_wr_en && csr_wr_data != utfc_pkg::FORM_UNUSED)
            form = csr_wr_data;
         expected_left = expected_out_q.size();
      end
   end

endmodule

// ===== verif/tb_utf8_to_unicode_form_transcoder_core.sv =====
// Testbench top for the UTF-8 transcoder: stimulus, stall phases and verdict.
module tb_utf8_to_unicode_form_transcoder_core;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 120;
   localparam int SETTLE_CYCLES  = 8;
   localparam int SEG_BYTES      = 17;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_out_byte;
   logic       rsp_char_last;
   logic       rsp_error;
   logic       csr_wr_en;
   logic [2:0] csr_wr_data;

   int fail_count;
   int expected_left;
   int bytes_in;
   int bytes_out;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int bytes_sent   = 0;
   int idle_cycles  = 0;
   logic hold_off   = 1'b0;
   logic hold_done  = 1'b0;

   logic [2:0] seg_form [8] = '{utfc_pkg::FORM_UTF16LE, utfc_pkg::FORM_UTF32BE,
                                utfc_pkg::FORM_CESU8,   utfc_pkg::FORM_ASCII,
                                utfc_pkg::FORM_UTF16BE, utfc_pkg::FORM_UTF32LE,
                                utfc_pkg::FORM_UTF8,    utfc_pkg::FORM_CESU8};

   utf8_to_unicode_form_transcoder_core dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_char_last(rsp_char_last),
      .rsp_error    (rsp_error),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   utf8_transcoder_checker transcode_check (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_char_last(rsp_char_last),
      .rsp_error    (rsp_error),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .expected_left(expected_left),
      .bytes_in     (bytes_in),
      .bytes_out    (bytes_out)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, or one long hold-off when asked.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off && !hold_done) begin
            hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   // Send the low n bytes of w, most significant first.
   task automatic send_seq(input logic [31:0] w, input int n);
      for (int i = n - 1; i >= 0; i--)
         send_byte(w[8*i +: 8]);
   endtask

   // Continuation byte; now and then with random top bits, which go unchecked.
   task automatic send_tail(input logic [5:0] v);
      if ($urandom_range(9) == 0)
         send_byte({2'($urandom), v});
      else
         send_byte({2'b10, v});
   endtask

   // Drain all expected beats, let the block settle, then write the form.
   task automatic set_form(input logic [2:0] f);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= f;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic send_random_char();
      int          pick;
      logic [20:0] cp;
      logic [7:0]  lead;
      pick = $urandom_range(99);
      cp   = 21'($urandom);
      if (pick < 22) begin
         send_byte({1'b0, cp[6:0]});
      end else if (pick < 42) begin
         send_byte({3'b110, cp[10:6]});
         send_tail(cp[5:0]);
      end else if (pick < 62) begin
         send_byte({4'b1110, cp[15:12]});
         send_tail(cp[11:6]);
         send_tail(cp[5:0]);
      end else if (pick < 80) begin
         if ($urandom_range(3) != 0)
            cp = 21'($urandom_range(0, 'h10FFFF));
         send_byte({5'b11110, cp[20:18]});
         send_tail(cp[17:12]);
         send_tail(cp[11:6]);
         send_tail(cp[5:0]);
      end else if (pick < 90) begin
         // stray continuation or 0xF8-0xFF lead: both open a 4-byte character
         if ($urandom_range(1) == 0)
            lead = 8'($urandom_range('h80, 'hBF));
         else
            lead = 8'($urandom_range('hF8, 'hFF));
         send_byte(lead);
         repeat (3) send_byte(8'($urandom));
      end else begin
         // lone noise byte; may leave a character open
         send_byte(8'($urandom));
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      csr_wr_en   = 1'b0;
      csr_wr_data = utfc_pkg::FORM_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats, no idling.
      send_seq(32'h00E282AC, 3);
      set_form(utfc_pkg::FORM_ASCII);
      send_seq(32'h00007FFF, 2);
      send_seq(32'h00000000, 1);
      set_form(utfc_pkg::FORM_UTF16LE);
      send_seq(32'hF09F9880, 4);
      set_form(utfc_pkg::FORM_UTF16BE);
      send_seq(32'hF7BFBFBF, 4);
      set_form(utfc_pkg::FORM_UTF32LE);
      send_seq(32'h0000C3A9, 2);
      set_form(utfc_pkg::FORM_UTF32BE);
      send_seq(32'hBFBF8081, 4);
      set_form(utfc_pkg::FORM_CESU8);
      send_seq(32'h0000DFBF, 2);
      send_seq(32'hF0908080, 4);
      send_seq(32'h000000E2, 1);
      // finish the open character in another form
      set_form(utfc_pkg::FORM_UTF16BE);
      send_seq(32'h000082AC, 2);
      set_form(utfc_pkg::FORM_UTF16LE);
      send_seq(32'h000000C3, 1);
      // ascii drops the open character
      set_form(utfc_pkg::FORM_ASCII);
      send_seq(32'h00000041, 1);
      set_form(utfc_pkg::FORM_UTF16LE);
      send_seq(32'h00000041, 1);
      // unused code must be ignored
      set_form(utfc_pkg::FORM_UNUSED);
      send_seq(32'h00000042, 1);

      for (int seg = 0; seg < 8; seg++) begin
         case (seg / 2)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 65; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 33; stall_pct = 33; end
         endcase
         set_form(seg_form[seg]);
         // back up the output while the sender keeps pushing
         if (seg == 1)
            hold_off = 1'b1;
         bytes_sent = 0;
         while (bytes_sent < SEG_BYTES)
            send_random_char();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run: %0d bytes in, %0d bytes out, all seven forms and the unused code",
               bytes_in, bytes_out);
      $display("run: idle and stall mixes incl. a long output hold-off; %0d mismatches",
               fail_count);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
src/utfc_pkg.sv
src/utfc_encode.sv
src/utf8_to_unicode_form_transcoder_core.sv
src/utfc_checker.sv
verif/utf8_transcoder_checker.sv
verif/tb_utf8_to_unicode_form_transcoder_core.sv
